FILE: rtl/core/assert_macros.svh
// Assertion macros for the checked RTL of the patch applier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with the reset as disable condition.
`define BDPA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bdpa assertion failed");

// Same-cycle implication.
`define BDPA_ASSERT_IMP(label, ante, cons) \
  `BDPA_ASSERT(label, (ante) |-> (cons))

// Next-cycle implication.
`define BDPA_ASSERT_NXT(label, ante, cons) \
  `BDPA_ASSERT(label, (ante) |=> (cons))

`endif

FILE: rtl/core/bdpa_pkg.sv
// Types, codes and constants of the binary delta patch applier.
package bdpa_pkg;

  localparam int unsigned ADDR_W       = 24;
  localparam int unsigned POS_BITS_DEF = 24;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CW_W         = 64;
  localparam int unsigned SIGN_BIT     = CW_W - 1;

  typedef enum logic [1:0] {
    REQ_CTRL  = 2'd0,
    REQ_DIFF  = 2'd1,
    REQ_EXTRA = 2'd2,
    REQ_START = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_CTRL  = 2'd0,
    KIND_DIFF  = 2'd1,
    KIND_EXTRA = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_KIND     = 3'd1,
    ERR_LEN      = 3'd2,
    ERR_OLD      = 3'd3,
    ERR_TOO_BIG  = 3'd4,
    ERR_VALUE    = 3'd5
  } err_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECT_LEN = 2'd0,
    CFG_OLD_LEN  = 2'd1,
    CFG_MAX_SIZE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ADDR_W-1:0] sect_len;
    logic [ADDR_W-1:0] old_len;
    logic [ADDR_W-1:0] max_size;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [CW_W-1:0] control_word;
    logic [7:0]      data_byte;
    logic [7:0]      old_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]        new_byte;
    logic              byte_valid;
    logic [ADDR_W-1:0] new_addr;
    logic [ADDR_W-1:0] old_addr;
    kind_e             expect_kind;
    err_e              error_code;
  } res_t;

endpackage

FILE: rtl/core/bdpa_if.sv
// Valid/ready channel interfaces for patch items and produced bytes.
interface bdpa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] control_word;
  logic [7:0]  data_byte;
  logic [7:0]  old_byte;

  modport source (output valid, req_type, control_word, data_byte, old_byte, input ready);
  modport sink   (input valid, req_type, control_word, data_byte, old_byte, output ready);
endinterface

interface bdpa_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  new_byte;
  logic        byte_valid;
  logic [23:0] new_addr;
  logic [23:0] old_addr;
  logic [1:0]  expect_kind;
  logic [2:0]  error_code;

  modport source (output valid, new_byte, byte_valid, new_addr, old_addr, expect_kind,
                  error_code, input ready);
  modport sink   (input valid, new_byte, byte_valid, new_addr, old_addr, expect_kind,
                  error_code, output ready);
endinterface

FILE: rtl/core/bdpa_cfg.sv
// Configuration registers of the patch applier.
module bdpa_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 we_i,
  input  logic [bdpa_pkg::CFG_IDX_W-1:0]       idx_i,
  input  logic [bdpa_pkg::ADDR_W-1:0]          wdata_i,
  output bdpa_pkg::cfg_t                       cfg_o
);

  bdpa_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (bdpa_pkg::cfg_idx_e'(idx_i))
        bdpa_pkg::CFG_SECT_LEN: cfg_d.sect_len = wdata_i;
        bdpa_pkg::CFG_OLD_LEN:  cfg_d.old_len  = wdata_i;
        bdpa_pkg::CFG_MAX_SIZE: cfg_d.max_size = wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sect_len <= '0;
      cfg_q.old_len  <= '0;
      cfg_q.max_size <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/bdpa_step.sv
// Section state and the per-item update of the patch applier.
module bdpa_step #(
  parameter int unsigned POS_BITS = bdpa_pkg::POS_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  bdpa_pkg::item_t item_i,
  input  bdpa_pkg::cfg_t  cfg_i,
  output bdpa_pkg::res_t  res_o
);

  localparam int unsigned AW = bdpa_pkg::ADDR_W;
  localparam int unsigned LW = POS_BITS;
  localparam int unsigned MW = (POS_BITS > AW) ? POS_BITS : AW;
  localparam int unsigned SW = MW + 1;
  // Old position is two's complement; the seek may push it below zero.
  localparam int unsigned OW = MW + 2;
  localparam int unsigned SB = bdpa_pkg::SIGN_BIT;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_CTRL  = 5'b00010,
    PH_DIFF  = 5'b00100,
    PH_EXTRA = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [1:0]        cidx_q, cidx_d;
  logic [LW-1:0]     diff_left_q, diff_left_d;
  logic [LW-1:0]     extra_left_q, extra_left_d;
  logic [OW-1:0]     seek_q, seek_d;
  logic [AW-1:0]     new_pos_q, new_pos_d;
  logic [OW-1:0]     old_pos_q, old_pos_d;
  bdpa_pkg::err_e    err_q, err_d;

  bdpa_pkg::kind_e   want, expect_k;
  logic [LW-1:0]     mag;
  logic              big, neg, is_ctrl;
  logic [OW-1:0]     seek_w, ad_old, ad_seek, ad_old_next;
  logic [AW-1:0]     np1, ad_np;
  logic [LW-1:0]     dl1, el1;
  logic              ad_over, ad_done, tr_new_over, tr_old_over;

  function automatic bdpa_pkg::kind_e kind_of(phase_e ph);
    bdpa_pkg::kind_e k;
    unique case (ph)
      PH_CTRL:  k = bdpa_pkg::KIND_CTRL;
      PH_DIFF:  k = bdpa_pkg::KIND_DIFF;
      PH_EXTRA: k = bdpa_pkg::KIND_EXTRA;
      default:  k = bdpa_pkg::KIND_DONE;
    endcase
    return k;
  endfunction

  always_comb begin
    mag     = item_i.control_word[LW-1:0];
    big     = |item_i.control_word[SB-1:LW];
    // A negative zero is treated as zero.
    neg     = item_i.control_word[SB] && (mag != '0);
    seek_w  = neg ? (OW'(0) - OW'(mag)) : OW'(mag);
    is_ctrl = (item_i.req_type == bdpa_pkg::REQ_CTRL);
    np1     = new_pos_q + AW'(1);
    dl1     = diff_left_q - LW'(1);
    el1     = extra_left_q - LW'(1);

    // Shared end-of-diff logic: entered from the third control word or the last diff beat.
    ad_np       = is_ctrl ? new_pos_q : np1;
    ad_old      = is_ctrl ? old_pos_q : old_pos_q + OW'(1);
    ad_seek     = is_ctrl ? seek_w : seek_q;
    ad_over     = (SW'(ad_np) + SW'(extra_left_q)) > SW'(cfg_i.sect_len);
    ad_done     = ad_np >= cfg_i.sect_len;
    ad_old_next = ad_old + ad_seek;

    tr_new_over = (SW'(new_pos_q) + SW'(diff_left_q)) > SW'(cfg_i.sect_len);
    tr_old_over = old_pos_q[OW-1] ||
                  ((old_pos_q + OW'(diff_left_q)) > OW'(cfg_i.old_len));
  end

  always_comb begin
    phase_d      = phase_q;
    cidx_d       = cidx_q;
    diff_left_d  = diff_left_q;
    extra_left_d = extra_left_q;
    seek_d       = seek_q;
    new_pos_d    = new_pos_q;
    old_pos_d    = old_pos_q;
    err_d        = err_q;
    want         = kind_of(phase_q);

    res_o = '0;

    if (err_q == bdpa_pkg::ERR_NONE) begin
      if (item_i.req_type != 2'(want)) begin
        err_d = bdpa_pkg::ERR_KIND;
      end else begin
        unique case (bdpa_pkg::req_e'(item_i.req_type))
          bdpa_pkg::REQ_START: begin
            if (cfg_i.sect_len > cfg_i.max_size) begin
              err_d = bdpa_pkg::ERR_TOO_BIG;
            end else begin
              new_pos_d    = '0;
              old_pos_d    = '0;
              cidx_d       = '0;
              diff_left_d  = '0;
              extra_left_d = '0;
              seek_d       = '0;
              phase_d      = (cfg_i.sect_len == '0) ? PH_DONE : PH_CTRL;
            end
          end
          bdpa_pkg::REQ_CTRL: begin
            if (big) begin
              err_d = bdpa_pkg::ERR_VALUE;
            end else if (cidx_q != 2'd2 && neg) begin
              err_d = bdpa_pkg::ERR_LEN;
            end else if (cidx_q == 2'd0) begin
              diff_left_d = mag;
              cidx_d      = 2'd1;
            end else if (cidx_q == 2'd1) begin
              extra_left_d = mag;
              cidx_d       = 2'd2;
            end else begin
              seek_d = seek_w;
              cidx_d = 2'd0;
              if (tr_new_over) begin
                err_d = bdpa_pkg::ERR_LEN;
              end else if (tr_old_over) begin
                err_d = bdpa_pkg::ERR_OLD;
              end else if (diff_left_q != '0) begin
                phase_d = PH_DIFF;
              end else if (ad_over) begin
                err_d = bdpa_pkg::ERR_LEN;
              end else if (extra_left_q != '0) begin
                phase_d = PH_EXTRA;
              end else begin
                old_pos_d = ad_old_next;
                phase_d   = ad_done ? PH_DONE : PH_CTRL;
              end
            end
          end
          bdpa_pkg::REQ_DIFF: begin
            res_o.new_byte   = item_i.data_byte + item_i.old_byte;
            res_o.byte_valid = 1'b1;
            res_o.new_addr   = new_pos_q;
            new_pos_d        = np1;
            old_pos_d        = ad_old;
            diff_left_d      = dl1;
            if (dl1 == '0) begin
              if (ad_over) begin
                err_d = bdpa_pkg::ERR_LEN;
              end else if (extra_left_q != '0) begin
                phase_d = PH_EXTRA;
              end else begin
                old_pos_d = ad_old_next;
                phase_d   = ad_done ? PH_DONE : PH_CTRL;
              end
            end
          end
          default: begin
            res_o.new_byte   = item_i.data_byte;
            res_o.byte_valid = 1'b1;
            res_o.new_addr   = new_pos_q;
            new_pos_d        = np1;
            extra_left_d     = el1;
            if (el1 == '0) begin
              old_pos_d = old_pos_q + seek_q;
              phase_d   = (np1 >= cfg_i.sect_len) ? PH_DONE : PH_CTRL;
            end
          end
        endcase
      end
    end

    expect_k = (err_d != bdpa_pkg::ERR_NONE) ? bdpa_pkg::KIND_DONE : kind_of(phase_d);
    res_o.expect_kind = expect_k;
    res_o.error_code  = err_d;
    if (expect_k == bdpa_pkg::KIND_DIFF && !old_pos_d[OW-1]) begin
      res_o.old_addr = old_pos_d[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      cidx_q       <= '0;
      diff_left_q  <= '0;
      extra_left_q <= '0;
      seek_q       <= '0;
      new_pos_q    <= '0;
      old_pos_q    <= '0;
      err_q        <= bdpa_pkg::ERR_NONE;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      cidx_q       <= cidx_d;
      diff_left_q  <= diff_left_d;
      extra_left_q <= extra_left_d;
      seek_q       <= seek_d;
      new_pos_q    <= new_pos_d;
      old_pos_q    <= old_pos_d;
      err_q        <= err_d;
    end
  end

endmodule

FILE: rtl/core/binary_delta_patch_applier.sv
// Items pass through the input register and then the output register; a stalled output holds the input register.
// Throughput: one item per cycle unless the output stalls; section state updates once per item in a single pass.
// The input register frees whenever the output register is empty or taken in the same cycle.
// Reset (async, active low) clears the section state, the error and both registers' valid flags.
// After reset the block waits for a start item; max_section_size resets to all ones.
`include "assert_macros.svh"

module binary_delta_patch_applier #(
  parameter int unsigned POS_BITS = bdpa_pkg::POS_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bdpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bdpa_pkg::ADDR_W-1:0]    cfg_wdata_i,
  bdpa_in_if.sink                        in_i,
  bdpa_out_if.source                     out_o
);

  bdpa_pkg::cfg_t  cfg;
  bdpa_pkg::item_t s1_item_q;
  bdpa_pkg::res_t  step_res, out_res_q;
  logic            s1_valid_q, s1_valid_d;
  logic            out_valid_q, out_valid_d;
  logic            in_fire, advance;

  bdpa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  bdpa_step #(.POS_BITS(POS_BITS)) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.req_type     <= in_i.req_type;
      s1_item_q.control_word <= in_i.control_word;
      s1_item_q.data_byte    <= in_i.data_byte;
      s1_item_q.old_byte     <= in_i.old_byte;
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.new_byte    = out_res_q.new_byte;
  assign out_o.byte_valid  = out_res_q.byte_valid;
  assign out_o.new_addr    = out_res_q.new_addr;
  assign out_o.old_addr    = out_res_q.old_addr;
  assign out_o.expect_kind = out_res_q.expect_kind;
  assign out_o.error_code  = out_res_q.error_code;

  // A byte comes with no error, or with the overrun found at the last diff beat.
  `BDPA_ASSERT_IMP(a_byte_err, out_valid_q && out_res_q.byte_valid, (out_res_q.error_code == bdpa_pkg::ERR_NONE) || (out_res_q.error_code == bdpa_pkg::ERR_LEN))
  // An error always parks the block: the expected kind reads done, and only a reset clears the error.
  `BDPA_ASSERT_IMP(a_err_parks, out_valid_q && (out_res_q.error_code != bdpa_pkg::ERR_NONE), out_res_q.expect_kind == bdpa_pkg::KIND_DONE)
  // The old address is only reported while diff beats are expected.
  `BDPA_ASSERT_IMP(a_old_addr_diff, out_valid_q && (out_res_q.old_addr != '0), out_res_q.expect_kind == bdpa_pkg::KIND_DIFF)
  // A processed item always lands in the output register.
  `BDPA_ASSERT_NXT(a_adv_out, advance, out_valid_q)

endmodule
